/* rtl/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and types for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int HUE_FRAC_BITS_DEF = 8;
	localparam int SAT_BITS          = 12;

	// hue sector picked by the maximum channel, ties go red, green, blue
	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

endpackage

/* rtl/hsl_if.sv */
// ----------------------------------------------------------------------------
// hsl_if
// Valid/ready channels for pixels in RGB form and results in HSL form.
// ----------------------------------------------------------------------------
interface hsl_rgb_if import hsl_pkg::*; #(
	parameter int CB = CHANNEL_BITS_DEF
) ();
	logic          valid;
	logic          ready;
	logic [CB-1:0] red;
	logic [CB-1:0] green;
	logic [CB-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface hsl_out_if import hsl_pkg::*; #(
	parameter int CB = CHANNEL_BITS_DEF,
	parameter int HF = HUE_FRAC_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [HF+2:0]       hue;
	logic [SAT_BITS-1:0] saturation;
	logic [CB:0]         lightness;

	modport source (output valid, hue, saturation, lightness, input ready);
	modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

/* rtl/rgb_to_hsl_converter_core.sv */
// Throughput: one pixel per clock unless the output stalls; set by the bit-per-stage divider pipeline.
// A stalled output holds the pipe; empty stages still fill behind it.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_core
// RGB to HSL conversion: max/min stage, two divider pipelines for hue and
// saturation, and an output stage that assembles the hue sector.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_core import hsl_pkg::*; #(
	parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hsl_rgb_if.sink    rgb,
	hsl_out_if.source  hsl
);

	localparam int CB  = CHANNEL_BITS;
	localparam int HF  = HUE_FRAC_BITS;
	localparam int HW  = HF + 3;
	localparam int LW  = CB + 1;
	localparam int QW  = (HF + 1 > SAT_BITS) ? HF + 1 : SAT_BITS;
	localparam int NS  = QW + 2;
	localparam int HNW = CB + HF + 1;
	localparam int SNW = CB + SAT_BITS;
	localparam int SW  = LW + 4;

	localparam logic [CB-1:0] CH_FULL  = {CB{1'b1}};
	localparam logic [HW-1:0] HUE_TURN = HW'(6) << HF;
	localparam logic [HW-1:0] HUE_GRN  = HW'(2) << HF;
	localparam logic [HW-1:0] HUE_BLU  = HW'(4) << HF;

	logic [NS-1:0] en;

	hsl_flow #(.NS(NS)) u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rgb.valid),
		.out_ready (hsl.ready),
		.in_ready  (rgb.ready),
		.out_valid (hsl.valid),
		.en        (en)
	);

	// ---------------- stage 1: max, min, numerators, divisors -------------
	logic [CB-1:0]  mx, mn, delta, den, op_p, op_m, mag;
	logic [LW-1:0]  sum;
	logic [HNW-1:0] hue_num;
	logic [SNW-1:0] sat_num;
	sector_t        sect;
	logic           neg, grey;

	always_comb begin
		if (rgb.red >= rgb.green && rgb.red >= rgb.blue) begin
			sect = SECT_RED;
			mx   = rgb.red;
			op_p = rgb.green;
			op_m = rgb.blue;
		end else if (rgb.green >= rgb.blue) begin
			sect = SECT_GREEN;
			mx   = rgb.green;
			op_p = rgb.blue;
			op_m = rgb.red;
		end else begin
			sect = SECT_BLUE;
			mx   = rgb.blue;
			op_p = rgb.red;
			op_m = rgb.green;
		end
		mn = rgb.red;
		if (rgb.green < mn) mn = rgb.green;
		if (rgb.blue < mn) mn = rgb.blue;
		delta = mx - mn;
		grey  = (delta == '0);
		neg   = op_p < op_m;
		mag   = neg ? (op_m - op_p) : (op_p - op_m);
		sum   = {1'b0, mx} + {1'b0, mn};
		den   = (sum <= {1'b0, CH_FULL}) ? sum[CB-1:0] : CB'({CH_FULL, 1'b0} - sum);
		// bias the dividend so a negative difference rounds toward minus infinity
		hue_num = {1'b0, mag, {HF{1'b0}}}
			+ (neg ? (HNW'(delta) - HNW'(1)) : HNW'(0));
		sat_num = {delta, {SAT_BITS{1'b0}}} - SNW'(delta);
	end

	logic [HNW-1:0] hn_s1;
	logic [SNW-1:0] sn_s1;
	logic [CB-1:0]  hd_s1, sd_s1;
	logic [SW-1:0]  side_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hn_s1   <= hue_num;
			hd_s1   <= delta;
			sn_s1   <= sat_num;
			sd_s1   <= den;
			side_s1 <= {grey, neg, sect, sum};
		end
	end

	// ---------------- divider stages ---------------------------------------
	logic [QW-1:0] quo_h, quo_s;

	hsl_div #(.NW(HNW), .DW(CB), .QW(QW)) u_div_hue (
		.clk (clk),
		.en  (en[QW:1]),
		.num (hn_s1),
		.den (hd_s1),
		.quo (quo_h)
	);

	hsl_div #(.NW(SNW), .DW(CB), .QW(QW)) u_div_sat (
		.clk (clk),
		.en  (en[QW:1]),
		.num (sn_s1),
		.den (sd_s1),
		.quo (quo_s)
	);

	// sideband rides along with the divider stages
	logic [SW-1:0] side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_side
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[1]) begin
					side_s[0] <= side_s1;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[i+1]) begin
					side_s[i] <= side_s[i-1];
				end
			end
		end
	end

	// ---------------- output stage ------------------------------------------
	logic                grey_d, neg_d;
	sector_t             sect_d;
	logic [LW-1:0]       sum_d;
	logic [HF:0]         hq;
	logic [HW-1:0]       base, hue_c;
	logic [SAT_BITS-1:0] sat_c;

	assign grey_d = side_s[QW-1][SW-1];
	assign neg_d  = side_s[QW-1][SW-2];
	assign sect_d = sector_t'(side_s[QW-1][LW+1:LW]);
	assign sum_d  = side_s[QW-1][LW-1:0];
	assign hq     = quo_h[HF:0];

	always_comb begin
		unique case (sect_d)
			SECT_RED:   base = neg_d ? HUE_TURN : '0;
			SECT_GREEN: base = HUE_GRN;
			SECT_BLUE:  base = HUE_BLU;
			default:    base = '0;
		endcase
		hue_c = neg_d ? (base - HW'(hq)) : (base + HW'(hq));
		sat_c = quo_s[SAT_BITS-1:0];
		if (grey_d) begin
			hue_c = '0;
			sat_c = '0;
		end
	end

	logic [HW-1:0]       hue_sn;
	logic [SAT_BITS-1:0] sat_sn;
	logic [LW-1:0]       light_sn;

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			hue_sn   <= hue_c;
			sat_sn   <= sat_c;
			light_sn <= sum_d;
		end
	end

	assign hsl.hue        = hue_sn;
	assign hsl.saturation = sat_sn;
	assign hsl.lightness  = light_sn;

endmodule

/* rtl/hsl_flow.sv */
// ----------------------------------------------------------------------------
// hsl_flow
// Valid bits and per-stage load enables of the pipeline. A stage loads when the
// output is ready or it or a later stage is empty, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module hsl_flow import hsl_pkg::*; #(
	parameter int NS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_ready,
	output logic          in_ready,
	output logic          out_valid,
	output logic [NS-1:0] en
);

	localparam logic [NS-1:0] ONES = {NS{1'b1}};

	logic [NS-1:0] v_q;

	// stage i may advance if the output drains or a hole sits at or after it
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			en[i] = out_ready || ((v_q >> i) != (ONES >> i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

`ifndef NO_ASSERTIONS
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(out_valid && out_ready))
		|=> ($countones(v_q) == $past($countones(v_q)) + 1))
		else $error("beat count did not grow on accept");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && out_valid && out_ready)
		|=> ($countones(v_q) == $past($countones(v_q)) - 1))
		else $error("beat count did not shrink on delivery");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		((~en & ~v_q) == '0))
		else $error("empty stage held");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&v_q))
		else $error("input stalled with a hole in the pipe");
`endif

endmodule

/* rtl/hsl_div.sv */
// ----------------------------------------------------------------------------
// hsl_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module hsl_div import hsl_pkg::*; #(
	parameter int NW = 20,
	parameter int DW = 8,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int EW = (NW > QW) ? NW : QW;

	logic [EW-1:0] num_ext;
	logic [DW-1:0] rem0;
	logic [DW-1:0] rem_s  [QW-1];
	logic [DW-1:0] den_s  [QW-1];
	logic [QW-1:0] bits_s [QW];

	assign num_ext = EW'(num);
	// the top part is below the divisor since the quotient fits in QW bits
	assign rem0    = DW'(num_ext >> QW);

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] bits_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in  = rem0;
			assign den_in  = den;
			assign bits_in = num_ext[QW-1:0];
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign bits_in = bits_s[i-1];
		end

		assign trial = {rem_in, bits_in[QW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		// shift the next dividend bit out, the quotient bit in
		always_ff @(posedge clk) begin
			if (en[i]) begin
				bits_s[i] <= {bits_in[QW-2:0], ge};
			end
		end

		if (i < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[i]) begin
					rem_s[i] <= ge ? DW'(diff) : DW'(trial);
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quo = bits_s[QW-1];

endmodule
